>>> src/assert_macros.svh
// shared assertion macros for the sweep sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every edge out of reset
`define ASSERT_ALWAYS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/tss_pkg.sv
package tss_pkg;

  localparam int STEP_TOTAL = 10;
  localparam int STEP_W     = 4;
  localparam int IDLE_W     = 11;
  localparam int INCR_W     = 8;

  localparam int SWEEP_SPAN        = 40000;
  localparam int SCAN_RAMP_PERIOD  = 2000;
  localparam int FIRST_RAMP_PERIOD = 10000;
  localparam int RAMP_DIV          = 10;

  localparam logic [15:0] KEY_LEVEL       = 16'd60000;
  localparam logic [15:0] OUT_MAX         = 16'd50000;
  localparam logic [15:0] START_LEVEL_RST = 16'd10000;
  localparam logic [15:0] STEP_SIZE       = 16'(SWEEP_SPAN / STEP_TOTAL);
  localparam logic [INCR_W-1:0] STEP_INCR =
    INCR_W'((SWEEP_SPAN / STEP_TOTAL) / (SCAN_RAMP_PERIOD / RAMP_DIV));
  localparam logic [IDLE_W-1:0] IDLE_WRAP = IDLE_W'(1500);

  // start_level / 1000 by reciprocal, exact for all 16-bit values
  localparam int DIVK_SH = 26;
  localparam int DIVK_D  = FIRST_RAMP_PERIOD / RAMP_DIV;
  localparam longint unsigned DIVK_M = ((64'd1 << DIVK_SH) + DIVK_D - 1) / DIVK_D;
  localparam int DIVK_PW = 16 + $clog2(DIVK_M + 1);

  // all phase periods are 2^k times 5^j with j <= 4, so timing runs on residues mod 625
  localparam int RES_MOD = 625;
  localparam int SUB_MOD = RES_MOD / 5;
  localparam int RES_W   = $clog2(RES_MOD);

  typedef logic [RES_W-1:0] res_t;

  localparam res_t WRAP_RES = RES_W'((64'd1 << 32) % RES_MOD);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_WAIT  = 3'd1,
    PH_RAMP  = 3'd2,
    PH_SCAN  = 3'd3,
    PH_HOLD  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [31:0] tick;
    logic [15:0] stick;
    res_t        res;
  } tss_item_t;

  // (a - b) mod 625 for a, b already reduced
  function automatic res_t res_sub(input res_t a, input res_t b);
    logic [RES_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[RES_W]) begin
      d = d + (RES_W+1)'(RES_MOD);
    end
    return d[RES_W-1:0];
  endfunction

  // 16 = 1 mod 5, so folding nibbles keeps the residue
  function automatic logic mod5_zero(input res_t e);
    logic [6:0] s1;
    logic [4:0] s2;
    logic [4:0] s3;
    s1 = 7'(e[RES_W-1:4]) + 7'(e[3:0]);
    s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
    s3 = 5'(s2[4]) + 5'(s2[3:0]);
    return (s3 == 5'd0) || (s3 == 5'd5) || (s3 == 5'd10) || (s3 == 5'd15);
  endfunction

  function automatic logic mod125_zero(input res_t e);
    return (e == RES_W'(0)) || (e == RES_W'(SUB_MOD)) || (e == RES_W'(2 * SUB_MOD)) ||
           (e == RES_W'(3 * SUB_MOD)) || (e == RES_W'(4 * SUB_MOD));
  endfunction

endpackage

>>> src/thrust_sweep_sequencer_unit.sv
// datapath: an accepted item passes the residue stages, then the sequencer stage that loads
//   the result register
// throughput: one item per cycle while m_tready holds; every stage has its own valid and takes
//   a new item as soon as the stage after it moves on
// reset: synchronous rst empties the pipeline, clears the sequencer state and sets
//   start_level to 10000; no clearing pass, items are taken on the first cycle after reset
module thrust_sweep_sequencer_unit
  import tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // start_level
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,       // [31:0] tick, [47:32] stick_thrust
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // [15:0] thrust_command
  output logic [1:0]  m_tuser        // [0] indicator, [1] save_pulse
);

  logic [15:0] start_level;
  logic        res_valid, res_ready;
  tss_item_t   res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level <= START_LEVEL_RST;
    end else if (cfg_we) begin
      start_level <= cfg_wdata;
    end
  end

  tss_residue u_residue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_tick   (s_tdata[31:0]),
    .in_stick  (s_tdata[47:32]),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_item  (res_item)
  );

  tss_core u_core (
    .clk            (clk),
    .rst            (rst),
    .start_level    (start_level),
    .in_valid       (res_valid),
    .in_ready       (res_ready),
    .in_item        (res_item),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .thrust_command (m_tdata),
    .indicator      (m_tuser[0]),
    .save_pulse     (m_tuser[1])
  );

endmodule

>>> src/tss_residue.sv
`include "assert_macros.svh"

module tss_residue
  import tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_tick,
  input  logic [15:0] in_stick,
  output logic        out_valid,
  input  logic        out_ready,
  output tss_item_t   out_item
);

  localparam int W_B1     = (1 << 8) % RES_MOD;
  localparam int W_B2     = (1 << 16) % RES_MOD;
  localparam int W_B3     = (1 << 24) % RES_MOD;
  localparam int S_MAX    = 255 * (1 + W_B1 + W_B2 + W_B3);
  localparam int S_W      = $clog2(S_MAX + 1);
  localparam int Q_W      = $clog2(S_MAX / RES_MOD + 1);
  localparam int RECIP_SH = 22;
  localparam int RECIP_M  = (1 << RECIP_SH) / RES_MOD;
  localparam int PROD_W   = S_W + $clog2(RECIP_M + 1);

  logic              v1, v2, v3, v4;
  logic              free1, free2, free3, free4;
  logic [31:0]       tick1, tick2, tick3;
  logic [15:0]       stick1, stick2, stick3;
  logic [S_W-1:0]    s2, s3;
  logic [Q_W-1:0]    q3;
  tss_item_t         item4;

  logic [S_W-1:0]    s_next;
  logic [PROD_W-1:0] prod_q;
  logic [Q_W-1:0]    q_next;
  logic [S_W-1:0]    r_raw;
  logic [S_W-1:0]    r_fix;

  assign free4    = !v4 || out_ready;
  assign free3    = !v3 || free4;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_ready = free1;

  // weighted byte sum keeps tick mod 625
  assign s_next = S_W'(tick1[7:0]) +
                  S_W'(tick1[15:8]) * S_W'(W_B1) +
                  S_W'(tick1[23:16]) * S_W'(W_B2) +
                  S_W'(tick1[31:24]) * S_W'(W_B3);

  // quotient estimate is exact or one short
  assign prod_q = PROD_W'(s2) * PROD_W'(RECIP_M);
  assign q_next = prod_q[RECIP_SH +: Q_W];

  assign r_raw = s3 - S_W'(q3) * S_W'(RES_MOD);
  assign r_fix = (r_raw >= S_W'(RES_MOD)) ? r_raw - S_W'(RES_MOD) : r_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      tick1  <= in_tick;
      stick1 <= in_stick;
    end
    if (free2) begin
      tick2  <= tick1;
      stick2 <= stick1;
      s2     <= s_next;
    end
    if (free3) begin
      tick3  <= tick2;
      stick3 <= stick2;
      s3     <= s2;
      q3     <= q_next;
    end
    if (free4) begin
      item4.tick  <= tick3;
      item4.stick <= stick3;
      item4.res   <= RES_W'(r_fix);
    end
  end

  assign out_valid = v4;
  assign out_item  = item4;

  `ASSERT_IMPLY(a_sum_bound, clk, rst, v2, s2 <= S_W'(S_MAX))
  `ASSERT_IMPLY(a_quot_close, clk, rst, v3, r_raw < S_W'(2 * RES_MOD))
  `ASSERT_IMPLY(a_res_range, clk, rst, v4, item4.res < RES_W'(RES_MOD))

endmodule

>>> src/tss_core.sv
`include "assert_macros.svh"

module tss_core
  import tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] start_level,
  input  logic        in_valid,
  output logic        in_ready,
  input  tss_item_t   in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] thrust_command,
  output logic        indicator,
  output logic        save_pulse
);

  logic               running, running_next;
  logic               key_armed, key_armed_next;
  phase_t             phase, phase_next;
  logic [31:0]        pst, pst_next;
  res_t               pst_res, pst_res_next;
  logic [15:0]        target_level, target_level_next;
  logic [15:0]        current_level, current_level_next;
  logic [INCR_W-1:0]  ramp_incr, ramp_incr_next;
  logic               scan_mode, scan_mode_next;
  logic [STEP_W-1:0]  step_count, step_count_next;
  logic [IDLE_W-1:0]  idle_count, idle_count_next;
  logic               indicator_on, indicator_on_next;
  logic               pulse_next;
  logic [15:0]        thrust_next;

  logic [INCR_W-1:0]  first_incr;
  logic [DIVK_PW-1:0] divk_prod;

  logic               res_ind, res_pulse;
  logic [15:0]        res_thrust;

  logic               ld;
  logic               armed_tmp, toggle, run_now;
  logic               borrow;
  res_t               e0, e;
  logic [3:0]         low;
  logic               z625, z125;
  logic               end_wait, end_first, end_scan_ramp, end_dwell, ramp_step;

  assign in_ready = !out_valid || out_ready;
  assign ld       = in_valid && in_ready;

  assign divk_prod = DIVK_PW'(start_level) * DIVK_PW'(DIVK_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_incr <= INCR_W'(START_LEVEL_RST / 16'(DIVK_D));
    end else begin
      first_incr <= divk_prod[DIVK_SH +: INCR_W];
    end
  end

  // phase timing from residues of tick and phase start
  assign borrow = in_item.tick < pst;
  assign e0     = res_sub(in_item.res, pst_res);
  // a wrapped tick adds 2^32 to the elapsed count
  assign e      = borrow ? res_sub(e0, RES_W'(RES_MOD) - WRAP_RES) : e0;
  assign low    = in_item.tick[3:0] - pst[3:0];
  assign z625   = (e == '0);
  assign z125   = mod125_zero(e);

  assign end_wait      = (low[2:0] == 3'd0) && z125;
  assign end_first     = (low == 4'd0) && z625;
  assign end_scan_ramp = (low == 4'd0) && z125;
  assign end_dwell     = (low[2:0] == 3'd0) && z625;
  assign ramp_step     = !low[0] && mod5_zero(e);

  // stick acts as a start/stop key
  assign armed_tmp = key_armed || (in_item.stick > KEY_LEVEL);
  assign toggle    = armed_tmp && (in_item.stick < KEY_LEVEL);
  assign run_now   = running ^ toggle;

  always_comb begin
    running_next       = run_now;
    key_armed_next     = armed_tmp && !toggle;
    phase_next         = phase;
    pst_next           = pst;
    pst_res_next       = pst_res;
    target_level_next  = target_level;
    current_level_next = current_level;
    ramp_incr_next     = ramp_incr;
    scan_mode_next     = scan_mode;
    step_count_next    = step_count;
    idle_count_next    = idle_count;
    indicator_on_next  = indicator_on;
    pulse_next         = 1'b0;

    if (run_now) begin
      idle_count_next = '0;
      unique case (phase)
        PH_START: begin
          indicator_on_next = 1'b1;
          phase_next        = PH_WAIT;
          pst_next          = in_item.tick;
          pst_res_next      = in_item.res;
        end
        PH_WAIT: begin
          if (end_wait) begin
            target_level_next = start_level;
            ramp_incr_next    = first_incr;
            phase_next        = PH_RAMP;
            pst_next          = in_item.tick;
            pst_res_next      = in_item.res;
          end
        end
        PH_RAMP: begin
          if (scan_mode ? end_scan_ramp : end_first) begin
            current_level_next = target_level;
            phase_next         = PH_SCAN;
            pst_next           = in_item.tick;
            pst_res_next       = in_item.res;
            if (!scan_mode) begin
              scan_mode_next  = 1'b1;
              step_count_next = '0;
            end
          end else if (ramp_step) begin
            current_level_next = current_level + 16'(ramp_incr);
          end
        end
        PH_SCAN: begin
          if (end_dwell) begin
            pst_next     = in_item.tick;
            pst_res_next = in_item.res;
            if (step_count < STEP_W'(STEP_TOTAL)) begin
              step_count_next   = step_count + STEP_W'(1);
              target_level_next = current_level + STEP_SIZE;
              ramp_incr_next    = STEP_INCR;
              phase_next        = PH_RAMP;
            end else begin
              target_level_next  = '0;
              current_level_next = '0;
              indicator_on_next  = 1'b0;
              phase_next         = PH_HOLD;
            end
          end
        end
        default: begin
          target_level_next  = '0;
          current_level_next = '0;
        end
      endcase
    end else begin
      if (idle_count > IDLE_WRAP) begin
        idle_count_next = '0;
        pulse_next      = 1'b1;
      end else begin
        idle_count_next = idle_count + IDLE_W'(1);
      end
      indicator_on_next  = 1'b0;
      target_level_next  = '0;
      current_level_next = '0;
      phase_next         = PH_START;
      scan_mode_next     = 1'b0;
      pst_next           = in_item.tick;
      pst_res_next       = in_item.res;
    end

    thrust_next = (current_level_next > OUT_MAX) ? OUT_MAX : current_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      key_armed     <= 1'b0;
      phase         <= PH_START;
      pst           <= '0;
      pst_res       <= '0;
      target_level  <= '0;
      current_level <= '0;
      ramp_incr     <= '0;
      scan_mode     <= 1'b0;
      step_count    <= '0;
      idle_count    <= '0;
      indicator_on  <= 1'b0;
    end else if (ld) begin
      running       <= running_next;
      key_armed     <= key_armed_next;
      phase         <= phase_next;
      pst           <= pst_next;
      pst_res       <= pst_res_next;
      target_level  <= target_level_next;
      current_level <= current_level_next;
      ramp_incr     <= ramp_incr_next;
      scan_mode     <= scan_mode_next;
      step_count    <= step_count_next;
      idle_count    <= idle_count_next;
      indicator_on  <= indicator_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_thrust <= thrust_next;
      res_ind    <= indicator_on_next;
      res_pulse  <= pulse_next;
    end
  end

  assign thrust_command = res_thrust;
  assign indicator      = res_ind;
  assign save_pulse     = res_pulse;

  `ASSERT_IMPLY(a_ind_phase, clk, rst, indicator_on,
                running && phase != PH_START && phase != PH_HOLD)
  `ASSERT_IMPLY(a_pulse_idle, clk, rst, out_valid && res_pulse, !running)
  `ASSERT_ALWAYS(a_step_bound, clk, rst, step_count <= STEP_W'(STEP_TOTAL))
  `ASSERT_NEXT(a_idle_clear, clk, rst, ld && !run_now,
               phase == PH_START && current_level == '0 && !indicator_on)

endmodule

>>> dv/thrust_sweep_sequencer_unit_tb.sv
`timescale 1ns / 100ps

module thrust_sweep_sequencer_unit_tb;
  import tss_pkg::*;

  localparam logic [31:0] WAIT_TICKS  = 32'd1000;
  localparam logic [31:0] FIRST_RAMP  = 32'd10000;
  localparam logic [31:0] SCAN_RAMP   = 32'd2000;
  localparam logic [31:0] DWELL_TICKS = 32'd5000;
  localparam logic [31:0] INCR_EVERY  = 32'd10;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          MAX_REPORTS = 40;

  typedef struct packed {
    logic [15:0] stick;
    logic [31:0] tick;
  } tick_item_t;

  typedef struct {
    logic [15:0] thrust;
    logic        indicator;
    logic        save_pulse;
  } sweep_cmd_t;

  typedef struct {
    logic [15:0] start_level;
    logic        running;
    logic        key_armed;
    phase_t      phase;
    logic [31:0] phase_start;
    logic [15:0] target;
    logic [15:0] current;
    logic [15:0] incr;
    logic        scan_mode;
    logic [3:0]  step_count;
    logic [10:0] idle_count;
    logic        indicator_on;
  } sweep_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = 48'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  tick_item_t   tick_queue[$];
  sweep_cmd_t   cmd_expected[$];
  sweep_state_t chk;
  sweep_state_t gen;
  logic [31:0]  gen_tick = 32'd0;

  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  bit  in_taken = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  int  errors = 0;
  int  ticks_in = 0;
  int  cmds_out = 0;
  int  holds_reached = 0;
  int  clamped = 0;
  int  pulses = 0;

  int          src_plan[8]   = '{0, 84, 0, 19, 0, 84, 0, 19};
  int          snk_plan[8]   = '{0, 0, 84, 19, 0, 0, 84, 19};
  logic [15:0] level_plan[8] = '{16'd65535, 16'd0, 16'd30000, 16'd1000,
                                 16'd50000, 16'd0, 16'd999, 16'd10000};

  thrust_sweep_sequencer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sweep_state_t sweep_reset_state();
    sweep_state_t s;
    s.start_level  = START_LEVEL_RST;
    s.running      = 1'b0;
    s.key_armed    = 1'b0;
    s.phase        = PH_START;
    s.phase_start  = 32'd0;
    s.target       = 16'd0;
    s.current      = 16'd0;
    s.incr         = 16'd0;
    s.scan_mode    = 1'b0;
    s.step_count   = 4'd0;
    s.idle_count   = 11'd0;
    s.indicator_on = 1'b0;
    return s;
  endfunction

  // one control tick through the sweep sequence
  task automatic sweep_advance(inout sweep_state_t s, input logic [31:0] tick,
                               input logic [15:0] stick, output sweep_cmd_t cmd);
    logic [31:0] elapsed;
    logic [31:0] ramp_len;
    logic        pulse;
    elapsed = tick - s.phase_start;
    pulse   = 1'b0;
    if (stick > KEY_LEVEL) s.key_armed = 1'b1;
    if (s.key_armed && stick < KEY_LEVEL) begin
      s.running   = !s.running;
      s.key_armed = 1'b0;
    end
    if (s.running) begin
      case (s.phase)
        PH_START: begin
          s.indicator_on = 1'b1;
          s.phase        = PH_WAIT;
          s.phase_start  = tick;
        end
        PH_WAIT: begin
          if (elapsed % WAIT_TICKS == 32'd0) begin
            s.target      = s.start_level;
            s.incr        = s.start_level / 16'd1000;
            s.phase       = PH_RAMP;
            s.phase_start = tick;
          end
        end
        PH_RAMP: begin
          ramp_len = s.scan_mode ? SCAN_RAMP : FIRST_RAMP;
          if (elapsed % ramp_len == 32'd0) begin
            s.current     = s.target;
            s.phase       = PH_SCAN;
            s.phase_start = tick;
            if (!s.scan_mode) begin
              s.scan_mode  = 1'b1;
              s.step_count = 4'd0;
            end
          end else if (elapsed % INCR_EVERY == 32'd0) begin
            s.current = s.current + s.incr;
          end
        end
        PH_SCAN: begin
          if (elapsed % DWELL_TICKS == 32'd0) begin
            if (s.step_count < STEP_TOTAL) begin
              s.step_count = s.step_count + 4'd1;
              s.target     = s.current + STEP_SIZE;
              s.incr       = STEP_SIZE / 16'd200;
              s.phase      = PH_RAMP;
            end else begin
              s.target       = 16'd0;
              s.current      = 16'd0;
              s.indicator_on = 1'b0;
              s.phase        = PH_HOLD;
            end
            s.phase_start = tick;
          end
        end
        default: begin
          s.target  = 16'd0;
          s.current = 16'd0;
        end
      endcase
      s.idle_count = 11'd0;
    end else begin
      if (s.idle_count > 11'd1500) begin
        s.idle_count = 11'd0;
        pulse        = 1'b1;
      end else begin
        s.idle_count = s.idle_count + 11'd1;
      end
      s.indicator_on = 1'b0;
      s.target       = 16'd0;
      s.current      = 16'd0;
      s.phase        = PH_START;
      s.scan_mode    = 1'b0;
      s.phase_start  = tick;
    end
    cmd.thrust     = (s.current > OUT_MAX) ? OUT_MAX : s.current;
    cmd.indicator  = s.indicator_on;
    cmd.save_pulse = pulse;
  endtask

  // the planning copy follows every queued item so ticks can land on phase ends
  task automatic push_item(input logic [31:0] tick, input logic [15:0] stick);
    sweep_cmd_t unused;
    tick_queue.push_back('{stick: stick, tick: tick});
    sweep_advance(gen, tick, stick, unused);
    gen_tick = tick;
  endtask

  task automatic queue_sweep_items(input int count);
    logic [31:0] t;
    logic [15:0] st;
    logic [31:0] ramp_len;
    int          roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      st   = 16'($urandom_range(59999));
      t    = gen_tick + INCR_EVERY;
      if (roll < 8) begin
        st = 16'($urandom);
        t  = (roll < 4) ? 32'($urandom) : gen_tick + 32'($urandom_range(3));
      end else if (gen.key_armed) begin
        t = gen_tick + 32'd1;
      end else if (!gen.running || (gen.phase == PH_HOLD && roll < 30) ||
                   $urandom_range(199) == 0) begin
        st = 16'($urandom_range(65535, 60001));
        t  = gen_tick + 32'd1;
      end else begin
        case (gen.phase)
          PH_WAIT: begin
            if (roll < 55) t = gen.phase_start + WAIT_TICKS * 32'($urandom_range(3, 1));
            else           t = gen_tick + 32'($urandom_range(999, 1));
          end
          PH_RAMP: begin
            ramp_len = gen.scan_mode ? SCAN_RAMP : FIRST_RAMP;
            if (roll < 35)      t = gen.phase_start + ramp_len;
            else if (roll < 90) t = gen_tick + INCR_EVERY;
            else                t = gen_tick + 32'($urandom_range(9));
          end
          PH_SCAN: begin
            if (roll < 55) t = gen.phase_start + DWELL_TICKS * 32'($urandom_range(2, 1));
            else           t = gen_tick + 32'($urandom_range(4999, 1));
          end
          default: t = gen_tick + 32'($urandom_range(100));
        endcase
      end
      // exactly at the key level: neither arms nor toggles
      if (roll == 8) st = KEY_LEVEL;
      push_item(t, st);
    end
  endtask

  // long idle stretch, long enough for the save pulse to come round
  task automatic queue_idle_items(input int count);
    logic [15:0] st;
    for (int n = 0; n < count; n++) begin
      if (gen.running)        st = gen.key_armed ? 16'($urandom_range(59999))
                                                 : 16'($urandom_range(65535, 60001));
      else if (gen.key_armed) st = 16'($urandom_range(65535, 60000));
      else                    st = 16'($urandom_range(60000));
      push_item($urandom, st);
    end
  endtask

  task automatic write_start_level(input logic [15:0] level);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(negedge clk);
    cfg_we <= 1'b0;
    chk.start_level = level;
    gen.start_level = level;
  endtask

  task automatic settle();
    while (tick_queue.size() != 0 || s_tvalid || cmd_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(negedge clk) begin : driver
    tick_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (tick_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = tick_queue.pop_front();
        s_tdata  <= it;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    sweep_cmd_t want;
    phase_t     was;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        was = chk.phase;
        sweep_advance(chk, s_tdata[31:0], s_tdata[47:32], want);
        cmd_expected.push_back(want);
        in_taken = 1'b1;
        ticks_in++;
        if (was != PH_HOLD && chk.phase == PH_HOLD) holds_reached++;
      end
      if (m_tvalid && m_tready) begin
        cmds_out++;
        if (cmd_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: command with nothing expected, thrust %0d user %b",
                     $time, m_tdata, m_tuser);
        end else begin
          want = cmd_expected.pop_front();
          if (want.thrust == OUT_MAX) clamped++;
          if (want.save_pulse) pulses++;
          if (m_tdata !== want.thrust)
            report_mismatch("thrust_command", want.thrust, m_tdata);
          if (m_tuser[0] !== want.indicator)
            report_mismatch("indicator", want.indicator, m_tuser[0]);
          if (m_tuser[1] !== want.save_pulse)
            report_mismatch("save_pulse", want.save_pulse, m_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    chk = sweep_reset_state();
    gen = sweep_reset_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // key handling, tick wrap across a run, first ramp and two scan steps
    push_item(32'd5, 16'd65535);
    push_item(32'd6, KEY_LEVEL);
    push_item(32'd7, 16'd60001);
    push_item(32'hFFFF_FC18, 16'd0);
    push_item(32'hFFFF_FC18, 16'd100);
    push_item(32'hFFFF_FC22, 16'd59999);
    push_item(32'hFFFF_FC23, 16'd0);
    push_item(32'd9000, 16'd0);
    push_item(32'd9000, 16'd7);
    push_item(32'd9010, 16'd0);
    push_item(32'd11000, 16'd0);
    push_item(32'd16000, 16'd0);
    push_item(32'd16010, 16'd0);
    push_item(32'd16001, 16'd65535);
    push_item(32'd16002, 16'd1234);
    push_item(32'hFFFF_FFFF, 16'd0);
    push_item(32'd0, 16'd65535);
    push_item(32'd1, 16'd0);
    push_item(32'd2, 16'd65535);
    push_item(32'd3, 16'd0);
    settle();

    for (int p = 0; p < 8; p++) begin
      src_idle_pct  = src_plan[p];
      snk_stall_pct = snk_plan[p];
      write_start_level(p == 5 ? 16'($urandom) : level_plan[p]);
      // receiver holds off while the sender keeps offering
      if (p == 4) hold_request = 1'b1;
      queue_sweep_items(70);
      settle();
    end

    src_idle_pct  = 19;
    snk_stall_pct = 19;
    queue_idle_items(1520);
    settle();

    if (cmd_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d commands never arrived", $time, cmd_expected.size());
    end
    $display("ran %0d ticks through 8 start levels under mixed flow control, %0d commands",
             ticks_in, cmds_out);
    $display("sweeps to hold %0d, clamped commands %0d, save pulses %0d",
             holds_reached, clamped, pulses);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
